// File: hdl/mws_pkg.sv
package mws_pkg;

  // Channel register layout
  localparam int NUM_REGS = 5;
  localparam int REG_IDX_W = 3;
  localparam int REG_W = 64;
  localparam int ADDR_W = 6;
  localparam int PHASE_W = 24;
  localparam int AMP_W = 12;
  localparam int DC_W = 12;
  localparam int OFFS_W = 14;
  localparam int SAMPLE_W = 16;
  localparam int IN_DATA_W = 8;

  // Defaults for top-level parameters
  localparam int DEF_NUM_WAVES = 5;
  localparam int DEF_SINE_TABLE_BITS = 10;

  // Shared multiplier operand widths
  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 17;
  localparam int PROD_W = MUL_A_W + MUL_B_W;

  // Polynomial sine coefficients, Q16
  localparam logic [MUL_B_W-1:0] SIN_A = 17'd102944;
  localparam logic [MUL_B_W-1:0] SIN_B = 17'd42047;
  localparam logic [MUL_B_W-1:0] SIN_C = 17'd4639;

  localparam logic signed [SAMPLE_W-1:0] SUM_LIMIT = 16'sd20475;

  typedef logic [REG_W-1:0] wave_t;

  localparam logic [1:0] FORM_OFF = 2'd0;
  localparam logic [1:0] FORM_SINE = 2'd1;
  localparam logic [1:0] FORM_SQUARE = 2'd2;
  localparam logic [1:0] FORM_TRIANGLE = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SIN1,
    S_SIN2,
    S_SIN3,
    S_SIN4,
    S_FIN,
    S_DONE
  } state_t;

endpackage

// File: hdl/mws_mul.sv
module mws_mul (
  input  logic                          clk,
  input  logic [mws_pkg::MUL_A_W-1:0]   a,
  input  logic [mws_pkg::MUL_B_W-1:0]   b,
  output logic [mws_pkg::PROD_W-1:0]    prod
);

  always_ff @(posedge clk) begin
    prod <= mws_pkg::PROD_W'(a) * mws_pkg::PROD_W'(b);
  end

endmodule

// File: hdl/mws_regs.sv
module mws_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mws_pkg::ADDR_W-1:0]   paddr,
  input  logic [mws_pkg::REG_W-1:0]    pwdata,
  output logic [mws_pkg::REG_W-1:0]    prdata,
  output mws_pkg::wave_t               wave [mws_pkg::NUM_REGS]
);

  logic [mws_pkg::REG_IDX_W-1:0] idx;
  logic                          in_range;

  assign idx = paddr[mws_pkg::ADDR_W-1:3];
  assign in_range = (idx < mws_pkg::REG_IDX_W'(mws_pkg::NUM_REGS));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mws_pkg::NUM_REGS; i++) begin
        wave[i] <= '0;
      end
    end else if (psel && penable && pwrite && in_range) begin
      wave[idx] <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (in_range) begin
      prdata = wave[idx];
    end
  end

endmodule

// File: hdl/multi_waveform_sum_generator.sv
// Per request, each channel passes LOAD and FIN, with SIN1 to SIN4 between them for a sine
// channel; DONE then presents the channel sum on m_tvalid.
// Requests are taken only in IDLE, so a new request waits until the last sweep is through;
// the single shared multiplier is used in LOAD and in each of SIN1 to SIN4 per sine channel. A new
// request is taken while a result waits; the next result then holds until m_tready.
// Reset (rst, synchronous): clears channel registers, phase accumulators, sequencer and
// output valid; no clearing pass.
module multi_waveform_sum_generator #(
  parameter int NUM_WAVES = mws_pkg::DEF_NUM_WAVES,
  parameter int SINE_TABLE_BITS = mws_pkg::DEF_SINE_TABLE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [mws_pkg::IN_DATA_W-1:0]   s_tdata,   // [0] restart, [7:1] zero
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mws_pkg::SAMPLE_W-1:0]    m_tdata,   // [15:0] sample, signed
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mws_pkg::ADDR_W-1:0]      paddr,
  input  logic [mws_pkg::REG_W-1:0]       pwdata,
  output logic [mws_pkg::REG_W-1:0]       prdata,
  output logic                            pready
);

  localparam int CH_W = (NUM_WAVES > 1) ? $clog2(NUM_WAVES) : 1;
  localparam int QB = SINE_TABLE_BITS - 2;
  localparam int XSH = 18 - SINE_TABLE_BITS;

  mws_pkg::wave_t wave [mws_pkg::NUM_REGS];
  mws_pkg::state_t state, state_next;

  logic [CH_W-1:0]                   ch;
  logic [mws_pkg::PHASE_W-1:0]       acc [NUM_WAVES];
  logic signed [mws_pkg::SAMPLE_W-1:0] sum, sum_next;
  logic [mws_pkg::MUL_B_W-1:0]       x2;
  logic [mws_pkg::MUL_A_W-1:0]       mul_a;
  logic [mws_pkg::MUL_B_W-1:0]       mul_b;
  logic [mws_pkg::PROD_W-1:0]        prod;

  mws_pkg::wave_t                    w;
  logic [1:0]                        form;
  logic [mws_pkg::AMP_W-1:0]         amp;
  logic [mws_pkg::DC_W-1:0]          dc;
  logic [mws_pkg::OFFS_W-1:0]        offs;
  logic [mws_pkg::PHASE_W-1:0]       inc;
  logic [mws_pkg::PHASE_W-1:0]       p;
  logic [mws_pkg::MUL_B_W-1:0]       x_raw, x;
  logic [22:0]                       m;
  logic [mws_pkg::MUL_B_W-1:0]       prod_hi;
  logic [28:0]                       sin_rnd;
  logic [34:0]                       tri_rnd;
  logic [12:0]                       mag;
  logic signed [mws_pkg::SAMPLE_W-1:0] volt;
  logic signed [mws_pkg::SAMPLE_W-1:0] sat;
  logic                              accept;
  logic                              last_ch;
  logic                              out_free;

  assign pready = 1'b1;

  mws_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .wave    (wave)
  );

  mws_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Field decode of the channel in progress
  assign w    = wave[mws_pkg::REG_IDX_W'(ch)];
  assign form = w[1:0];
  assign amp  = w[13:2];
  assign dc   = w[25:14];
  assign offs = w[39:26];
  assign inc  = w[63:40];

  assign p = acc[ch] + {offs, 10'd0};

  // Quarter-wave fraction; mirror in odd quarters
  assign x_raw = {1'b0, p[21 -: QB], {XSH{1'b0}}};
  assign x = p[22] ? (17'd65536 - x_raw) : x_raw;
  assign m = p[22] ? (23'h400000 - {1'b0, p[21:0]}) : {1'b0, p[21:0]};

  assign prod_hi = prod[32:16];
  assign sin_rnd = prod[28:0] + 29'd32768;
  assign tri_rnd = prod[34:0] + 35'h200000;

  always_comb begin
    case (form)
      mws_pkg::FORM_SINE:     mag = sin_rnd[28:16];
      mws_pkg::FORM_TRIANGLE: mag = tri_rnd[34:22];
      mws_pkg::FORM_SQUARE:   mag = {1'b0, amp};
      default:                mag = '0;
    endcase
  end

  always_comb begin
    if (form == mws_pkg::FORM_OFF) begin
      volt = '0;
    end else if (p[23]) begin
      volt = $signed({{4{dc[11]}}, dc}) - $signed({3'b000, mag});
    end else begin
      volt = $signed({{4{dc[11]}}, dc}) + $signed({3'b000, mag});
    end
  end

  assign sum_next = sum + volt;

  always_comb begin
    if (sum > mws_pkg::SUM_LIMIT) begin
      sat = mws_pkg::SUM_LIMIT;
    end else if (sum < -mws_pkg::SUM_LIMIT) begin
      sat = -mws_pkg::SUM_LIMIT;
    end else begin
      sat = sum;
    end
  end

  assign accept   = s_tvalid && s_tready;
  assign last_ch  = (ch == CH_W'(NUM_WAVES - 1));
  assign out_free = !m_tvalid || m_tready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      mws_pkg::S_IDLE: begin
        if (s_tvalid) state_next = mws_pkg::S_LOAD;
      end
      mws_pkg::S_LOAD: begin
        if (form == mws_pkg::FORM_SINE) begin
          state_next = mws_pkg::S_SIN1;
        end else begin
          state_next = mws_pkg::S_FIN;
        end
      end
      mws_pkg::S_SIN1: state_next = mws_pkg::S_SIN2;
      mws_pkg::S_SIN2: state_next = mws_pkg::S_SIN3;
      mws_pkg::S_SIN3: state_next = mws_pkg::S_SIN4;
      mws_pkg::S_SIN4: state_next = mws_pkg::S_FIN;
      mws_pkg::S_FIN: begin
        state_next = last_ch ? mws_pkg::S_DONE : mws_pkg::S_LOAD;
      end
      mws_pkg::S_DONE: begin
        if (out_free) state_next = mws_pkg::S_IDLE;
      end
      default: state_next = mws_pkg::S_IDLE;
    endcase
  end

  // Outputs: ready and multiplier operands
  always_comb begin
    s_tready = 1'b0;
    mul_a = '0;
    mul_b = '0;
    case (state)
      mws_pkg::S_IDLE: s_tready = 1'b1;
      mws_pkg::S_LOAD: begin
        if (form == mws_pkg::FORM_SINE) begin
          mul_a = mws_pkg::MUL_A_W'(x);
          mul_b = x;
        end else if (form == mws_pkg::FORM_TRIANGLE) begin
          mul_a = {1'b0, m};
          mul_b = mws_pkg::MUL_B_W'(amp);
        end
      end
      mws_pkg::S_SIN1: begin
        mul_a = mws_pkg::MUL_A_W'(mws_pkg::SIN_C);
        mul_b = prod_hi;
      end
      mws_pkg::S_SIN2: begin
        mul_a = mws_pkg::MUL_A_W'(mws_pkg::SIN_B - prod_hi);
        mul_b = x2;
      end
      mws_pkg::S_SIN3: begin
        mul_a = mws_pkg::MUL_A_W'(mws_pkg::SIN_A - prod_hi);
        mul_b = x;
      end
      mws_pkg::S_SIN4: begin
        mul_a = mws_pkg::MUL_A_W'(prod_hi);
        mul_b = mws_pkg::MUL_B_W'(amp);
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == mws_pkg::S_SIN1) begin
      x2 <= prod_hi;
    end
    if (state == mws_pkg::S_DONE && out_free) begin
      m_tdata <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mws_pkg::S_IDLE;
      ch <= '0;
      sum <= '0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < NUM_WAVES; i++) begin
        acc[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == mws_pkg::S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        mws_pkg::S_IDLE: begin
          if (accept) begin
            ch <= '0;
            sum <= '0;
            if (s_tdata[0]) begin
              for (int i = 0; i < NUM_WAVES; i++) begin
                acc[i] <= '0;
              end
            end
          end
        end
        mws_pkg::S_FIN: begin
          sum <= sum_next;
          acc[ch] <= acc[ch] + inc;
          if (!last_ch) ch <= ch + CH_W'(1);
        end
        default: begin
          ch <= ch;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == mws_pkg::S_LOAD)
    else $error("accepted request did not start the channel sweep");

  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata) <= mws_pkg::SUM_LIMIT &&
                  $signed(m_tdata) >= -mws_pkg::SUM_LIMIT))
    else $error("sample outside saturation range");

  a_ch_range: assert property (@(posedge clk) disable iff (rst)
    state != mws_pkg::S_IDLE |-> ch <= CH_W'(NUM_WAVES - 1))
    else $error("channel counter out of range");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    accept && s_tdata[0] |=> acc[0] == '0)
    else $error("restart did not clear phase");
`endif

endmodule

// File: test/multi_waveform_sum_generator_tb.sv
module multi_waveform_sum_generator_tb;

  localparam int NUM_CH = mws_pkg::DEF_NUM_WAVES;
  localparam int TBL_BITS = mws_pkg::DEF_SINE_TABLE_BITS;
  localparam int DRAIN_CYCLES = 40;
  localparam int DRAIN_LIMIT = 20000;
  localparam longint RUN_LIMIT = 64'd12 * 64'd1000000;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [mws_pkg::IN_DATA_W-1:0] s_tdata;   // [0] restart, [7:1] zero
  logic m_tvalid;
  logic m_tready;
  logic [mws_pkg::SAMPLE_W-1:0] m_tdata;    // [15:0] sample, signed
  logic psel;
  logic penable;
  logic pwrite;
  logic [mws_pkg::ADDR_W-1:0] paddr;
  logic [mws_pkg::REG_W-1:0] pwdata;
  logic [mws_pkg::REG_W-1:0] prdata;
  logic pready;

  // Shadow copy of the channel registers and phase accumulators
  mws_pkg::wave_t wave_cfg [mws_pkg::NUM_REGS];
  logic [mws_pkg::PHASE_W-1:0] phase_acc [mws_pkg::NUM_REGS];

  logic [mws_pkg::SAMPLE_W-1:0] expected_samples [$];
  logic [mws_pkg::SAMPLE_W-1:0] want_sample;
  int errors = 0;
  int samples_checked = 0;
  int settings_used = 0;
  int restarts_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  multi_waveform_sum_generator dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #(RUN_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // Q16 quarter-wave sine magnitude, every product truncated
  function automatic longint quarter_sine(input longint x);
    longint x2, t;
    x2 = (x * x) >>> 16;
    t = (longint'(mws_pkg::SIN_C) * x2) >>> 16;
    t = longint'(mws_pkg::SIN_B) - t;
    t = (t * x2) >>> 16;
    t = longint'(mws_pkg::SIN_A) - t;
    t = (t * x) >>> 16;
    return t;
  endfunction

  function automatic int chan_volt(input mws_pkg::wave_t w,
                                   input logic [mws_pkg::PHASE_W-1:0] acc);
    longint amp, mag, m, r, x;
    int dc;
    logic [mws_pkg::PHASE_W-1:0] p;
    logic [1:0] q;
    logic [TBL_BITS-1:0] k;
    amp = longint'(w[13:2]);
    dc = int'($signed(w[25:14]));
    p = acc + {w[39:26], 10'd0};
    q = p[mws_pkg::PHASE_W-1 -: 2];
    if (w[1:0] == mws_pkg::FORM_OFF) return 0;
    if (w[1:0] == mws_pkg::FORM_SQUARE)
      return p[mws_pkg::PHASE_W-1] ? dc - int'(amp) : dc + int'(amp);
    if (w[1:0] == mws_pkg::FORM_TRIANGLE) begin
      r = longint'(p[mws_pkg::PHASE_W-3:0]);
      m = q[0] ? (64'sd4194304 - r) : r;
      mag = (amp * m + 64'sd2097152) >>> 22;
    end else begin
      k = p[mws_pkg::PHASE_W-1 -: TBL_BITS];
      q = k[TBL_BITS-1 -: 2];
      x = longint'(k[TBL_BITS-3:0]) << (16 - (TBL_BITS - 2));
      if (q[0]) x = 64'sd65536 - x;
      mag = (amp * quarter_sine(x) + 64'sd32768) >>> 16;
    end
    return q[1] ? dc - int'(mag) : dc + int'(mag);
  endfunction

  // Form the channel sum for one tick, then advance the accumulators
  function automatic void predict_sample(input bit restart);
    int total;
    total = 0;
    if (restart) foreach (phase_acc[i]) phase_acc[i] = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      total += chan_volt(wave_cfg[i], phase_acc[i]);
      phase_acc[i] = phase_acc[i] + wave_cfg[i][63:40];
    end
    if (total > int'(mws_pkg::SUM_LIMIT)) total = int'(mws_pkg::SUM_LIMIT);
    if (total < -int'(mws_pkg::SUM_LIMIT)) total = -int'(mws_pkg::SUM_LIMIT);
    expected_samples.push_back(total[mws_pkg::SAMPLE_W-1:0]);
  endfunction

  function automatic mws_pkg::wave_t make_wave(input logic [1:0] form,
                                               input logic [11:0] amp,
                                               input logic [11:0] dc,
                                               input logic [13:0] offs,
                                               input logic [23:0] inc);
    return {inc, offs, dc, amp, form};
  endfunction

  function automatic mws_pkg::wave_t rand_wave(input bit loud);
    logic [1:0] form;
    logic [11:0] amp, dc;
    logic [13:0] offs;
    logic [23:0] inc;
    form = 2'($urandom_range(3));
    case ($urandom_range(3))
      0: amp = '0;
      1: amp = '1;
      default: amp = 12'($urandom);
    endcase
    if (loud) amp = '1;
    case ($urandom_range(3))
      0: dc = 12'h800;
      1: dc = 12'h7FF;
      default: dc = 12'($urandom);
    endcase
    offs = 14'($urandom);
    case ($urandom_range(4))
      0: inc = '1;
      1: inc = 24'($urandom_range(255));
      default: inc = 24'($urandom);
    endcase
    return make_wave(form, amp, dc, offs, inc);
  endfunction

  task automatic write_wave(input int idx, input mws_pkg::wave_t val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= mws_pkg::ADDR_W'(idx * 8);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx < mws_pkg::NUM_REGS) wave_cfg[idx] = val;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(input bit restart);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(mws_pkg::IN_DATA_W-1){1'b0}}, restart};
    do @(posedge clk); while (!s_tready);
    predict_sample(restart);
    if (restart) restarts_sent++;
  endtask

  // Hold off the sender until every expected sample is back, or until DRAIN_LIMIT runs out
  task automatic wait_drain();
    int n;
    n = 0;
    s_tvalid <= 1'b0;
    while (expected_samples.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_pacing(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
      default: begin send_idle_pct = 35; recv_stall_pct = 35; end
    endcase
  endtask

  always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_samples.size() == 0) begin
        $error("sample: no expectation waiting, actual %0d", $signed(m_tdata));
        errors++;
      end else begin
        want_sample = expected_samples.pop_front();
        samples_checked++;
        if (m_tdata !== want_sample) begin
          $error("sample: expected %0d, actual %0d", $signed(want_sample), $signed(m_tdata));
          errors++;
        end
      end
    end
  end

  task automatic test_reset_output();
    send_sample(1'b0);
    send_sample(1'b1);
    wait_drain();
  endtask

  task automatic test_wave_forms();
    write_wave(0, make_wave(mws_pkg::FORM_SINE, 12'hFFF, 12'h000, 14'h0000, 24'h100000));
    write_wave(1, make_wave(mws_pkg::FORM_SQUARE, 12'hFFF, 12'h800, 14'h3FFF, 24'h400000));
    write_wave(2, make_wave(mws_pkg::FORM_TRIANGLE, 12'hFFF, 12'h7FF, 14'h0000, 24'h200000));
    // off channel carries dc that must not show up
    write_wave(3, make_wave(mws_pkg::FORM_OFF, 12'hFFF, 12'h7FF, 14'h1234, 24'hFFFFFF));
    write_wave(4, make_wave(mws_pkg::FORM_SINE, 12'h001, 12'hFFF, 14'h2000, 24'hFFFFFF));
    settings_used++;
    for (int i = 0; i < 12; i++) send_sample(i == 0 || i == 7);
    wait_drain();
  endtask

  task automatic test_saturation();
    write_wave(5, '1);
    write_wave(7, '1);
    for (int c = 0; c < NUM_CH; c++)
      write_wave(c, make_wave(mws_pkg::FORM_SQUARE, 12'hFFF, 12'h7FF, 14'h0000, 24'h000000));
    settings_used++;
    send_sample(1'b1);
    send_sample(1'b0);
    wait_drain();
    // half-turn offset puts every square on its low level
    for (int c = 0; c < NUM_CH; c++)
      write_wave(c, make_wave(mws_pkg::FORM_SQUARE, 12'hFFF, 12'h800, 14'h2000, 24'h000000));
    settings_used++;
    send_sample(1'b0);
    send_sample(1'b1);
    wait_drain();
  endtask

  task automatic test_random_phase(input int mode, input int count, input bit loud);
    wait_drain();
    for (int c = 0; c < NUM_CH; c++) write_wave(c, rand_wave(loud));
    settings_used++;
    set_pacing(mode);
    for (int i = 0; i < count; i++) begin
      send_sample($urandom_range(99) < 3);
      if ($urandom_range(199) == 0) wait_drain();
    end
    wait_drain();
    set_pacing(0);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    foreach (wave_cfg[i]) begin
      wave_cfg[i] = '0;
      phase_acc[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_output();
    test_wave_forms();
    test_saturation();
    for (int ph = 0; ph < 8; ph++) test_random_phase(ph % 4, 130, ph == 5);

    wait_drain();
    if (expected_samples.size() != 0) begin
      $error("sample: %0d expected samples never arrived", expected_samples.size());
      errors++;
    end
    $display("Checked %0d samples over %0d register settings, %0d restarts,",
             samples_checked, settings_used, restarts_sent);
    $display("all wave forms, both saturation limits and four pacing modes.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/mws_pkg.sv
hdl/mws_mul.sv
hdl/mws_regs.sv
hdl/multi_waveform_sum_generator.sv
test/multi_waveform_sum_generator_tb.sv
